/* rtl/core/plsg_pkg.sv */
// ----------------------------------------------------------------------------
// plsg_pkg
// Shared constants, types and helpers for the piecewise linear segmenter.
// ----------------------------------------------------------------------------
package plsg_pkg;

    // window limits
    localparam int MAX_POINTS = 1024;
    localparam int TIME_SHIFT = 10;
    localparam int X_BITS     = 20;

    // field and state widths
    localparam int COUNT_W = 11;
    localparam int TIME_W  = 63;
    localparam int VALUE_W = 16;
    localparam int FIT_W   = 32;
    localparam int THR_W   = 16;
    localparam int SX_W    = 30;
    localparam int SXX_W   = 50;
    localparam int SXY_W   = 47;
    localparam int SY_W    = 27;
    localparam int SYY_W   = 41;
    localparam int YY_W    = 31;
    localparam int PAR_W   = 48;

    // intermediate widths of the fit
    localparam int DX_W   = 61;
    localparam int DY_W   = 51;
    localparam int NXY_W  = 58;
    localparam int LHS_W  = 116;
    localparam int TT_W   = 67;
    localparam int NCM_W  = 77;
    localparam int SUM_W  = 62;
    localparam int TERM_W = 60;

    // fixed point positions
    localparam int SLOPE_FRAC  = 24;
    localparam int OFFSET_FRAC = 11;
    localparam int END_SCALE   = 5;
    localparam int TERM_SHIFT  = 8;
    localparam int R2_SHIFT    = 16;

    // shared multiplier
    localparam int MAC_A_W   = 67;
    localparam int MAC_B_W   = 64;
    localparam int DIGIT_W   = 16;
    localparam int DIGIT_LOG = 4;
    localparam int PROD_W    = MAC_A_W + DIGIT_W;
    localparam int ACC_W     = 128;

    // divider
    localparam int NUM_W     = 89;
    localparam int QUOT_W    = 48;
    localparam int DIV_CNT_W = 6;

    // register map
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam logic REG_R2  = 1'b0;
    localparam logic [THR_W-1:0] R2_RESET = 16'd62259;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_YY,
        ST_MUL_XX,
        ST_MUL_XY,
        ST_DX_A,
        ST_DX_B,
        ST_DY_A,
        ST_DY_B,
        ST_NXY_A,
        ST_NXY_B,
        ST_SQ,
        ST_DYT,
        ST_RHS,
        ST_NCM_A,
        ST_NCM_B,
        ST_DIV_S,
        ST_DIV_O,
        ST_COMMIT,
        ST_FIT_END,
        ST_EMIT0,
        ST_EMIT1,
        ST_RESTART
    } state_t;

    typedef struct packed {
        logic [MAC_A_W-1:0] a;
        logic               a_neg;
        logic [MAC_B_W-1:0] b;
        logic [1:0]         last_digit;
        logic               clear;
    } mac_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    function automatic logic signed [FIT_W-1:0] sat_fit(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi_lim;
        logic signed [SUM_W-1:0] lo_lim;
        hi_lim = SUM_W'(64'sd2147483647);
        lo_lim = -SUM_W'(64'sd2147483648);
        if (v > hi_lim) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo_lim) begin
            return 32'sh80000000;
        end
        return v[FIT_W-1:0];
    endfunction

endpackage

/* rtl/core/plsg_mac.sv */
// ----------------------------------------------------------------------------
// plsg_mac
// Shared multiply-accumulate unit, one 16-bit digit of b per cycle.
// ----------------------------------------------------------------------------
module plsg_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  plsg_pkg::mac_cmd_t                     cmd,
    output plsg_pkg::unit_sts_t                    sts,
    output logic signed [plsg_pkg::ACC_W-1:0]      acc
);

    plsg_pkg::mac_cmd_t                      cmd_reg;
    logic [1:0]                              digit_reg;
    logic                                    busy_reg;
    logic                                    done_reg;
    logic signed [plsg_pkg::ACC_W-1:0]       acc_reg;

    logic [plsg_pkg::DIGIT_W-1:0]            b_digit;
    logic [plsg_pkg::PROD_W-1:0]             prod;
    logic [plsg_pkg::ACC_W-1:0]              term;

    assign b_digit = cmd_reg.b[{digit_reg, {plsg_pkg::DIGIT_LOG{1'b0}}} +: plsg_pkg::DIGIT_W];
    assign prod    = {{plsg_pkg::DIGIT_W{1'b0}}, cmd_reg.a}
                   * {{plsg_pkg::MAC_A_W{1'b0}}, b_digit};
    assign term    = plsg_pkg::ACC_W'(prod) << {digit_reg, {plsg_pkg::DIGIT_LOG{1'b0}}};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            digit_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            digit_reg <= '0;
        end
        else if (busy_reg)
        begin
            digit_reg <= digit_reg + 2'd1;
            if (digit_reg == cmd_reg.last_digit)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg <= cmd;
            if (cmd.clear)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (cmd_reg.a_neg)
            begin
                acc_reg <= acc_reg - $signed(term);
            end
            else
            begin
                acc_reg <= acc_reg + $signed(term);
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign acc      = acc_reg;

endmodule

/* rtl/core/plsg_div.sv */
// ----------------------------------------------------------------------------
// plsg_div
// Restoring divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module plsg_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [plsg_pkg::NUM_W-1:0]        num,
    input  logic [plsg_pkg::DX_W-1:0]         den,
    output plsg_pkg::unit_sts_t               sts,
    output logic [plsg_pkg::QUOT_W-2:0]       quot
);

    localparam int HI_W = plsg_pkg::NUM_W - plsg_pkg::QUOT_W;

    logic                                busy_reg;
    logic                                done_reg;
    logic [plsg_pkg::DIV_CNT_W-1:0]      count_reg;
    logic                                sat_reg;
    logic [plsg_pkg::DX_W-1:0]           den_reg;
    logic [plsg_pkg::DX_W-1:0]           rem_reg;
    logic [plsg_pkg::QUOT_W-1:0]         low_reg;

    logic [plsg_pkg::DX_W-1:0]           num_hi;
    logic                                start_sat;
    logic [plsg_pkg::DX_W:0]             trial;
    logic [plsg_pkg::DX_W:0]             diff;
    logic                                ge;

    // quotient of 2^48 or more saturates at once
    assign num_hi    = plsg_pkg::DX_W'(num[plsg_pkg::NUM_W-1:plsg_pkg::QUOT_W]);
    assign start_sat = (num_hi >= den);
    assign trial     = {rem_reg, low_reg[plsg_pkg::QUOT_W-1]};
    assign diff      = trial - {1'b0, den_reg};
    assign ge        = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= !start_sat;
            done_reg  <= start_sat;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == plsg_pkg::DIV_CNT_W'(plsg_pkg::QUOT_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sat_reg <= start_sat;
            den_reg <= den;
            rem_reg <= num_hi;
            low_reg <= num[plsg_pkg::QUOT_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[plsg_pkg::DX_W-1:0] : trial[plsg_pkg::DX_W-1:0];
            low_reg <= {low_reg[plsg_pkg::QUOT_W-2:0], ge};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = (sat_reg || low_reg[plsg_pkg::QUOT_W-1])
                    ? {(plsg_pkg::QUOT_W-1){1'b1}} : low_reg[plsg_pkg::QUOT_W-2:0];

endmodule

/* rtl/core/piecewise_linear_segmenter_core.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_segmenter_core
// Least-squares line segmenter over a growing sample window, refitted from
// running sums by one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
//
//  channel   | dir | word                              | handshake
//  ----------+-----+-----------------------------------+-------------------
//  sample    | in  | sample_time, sample_value         | valid / stall
//  point     | out | point_time, fit_value, last       | valid / stall
//  config    | in  | r2_threshold at byte address 0    | apb, pready high
//
//  a sample with a full refit is paced by the 16-bit digit passes of the
//  shared multiplier and two bit-serial divisions of 48 quotient bits
//  a sample with zero time spread skips the rest of the fit, a window open
//  skips the fit entirely, and a close ends in the two output words
//  the block takes one sample at a time: sample_stall is high from accept
//  until the sequencer is back in idle, after any output words are taken
//  point_stall holds the output word and the whole block
//  reset clears all window state and loads r2_threshold with 0.95
//
module piecewise_linear_segmenter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // sample channel
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic [plsg_pkg::TIME_W-1:0]          sample_time,
    input  logic signed [plsg_pkg::VALUE_W-1:0]  sample_value,
    // point channel
    output logic                                 point_valid,
    input  logic                                 point_stall,
    output logic [plsg_pkg::TIME_W-1:0]          point_time,
    output logic signed [plsg_pkg::FIT_W-1:0]    fit_value,
    output logic                                 last,
    // config port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [plsg_pkg::ADDR_W-1:0]          paddr,
    input  logic [plsg_pkg::DATA_W-1:0]          pwdata,
    output logic [plsg_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    // sequencer
    plsg_pkg::state_t state_reg;
    plsg_pkg::state_t state_next;
    logic             launched_reg;
    logic             launched_next;

    // config
    logic [plsg_pkg::THR_W-1:0] thr_reg;

    // window state
    logic [plsg_pkg::COUNT_W-1:0]       count_reg;
    logic [plsg_pkg::TIME_W-1:0]        wst_reg;
    logic [plsg_pkg::TIME_W-1:0]        prev_reg;
    logic [plsg_pkg::SX_W-1:0]          sum_x_reg;
    logic [plsg_pkg::SXX_W-1:0]         sum_xx_reg;
    logic signed [plsg_pkg::SXY_W-1:0]  sum_xy_reg;
    logic signed [plsg_pkg::SY_W-1:0]   sum_y_reg;
    logic [plsg_pkg::SYY_W-1:0]         sum_yy_reg;
    logic signed [plsg_pkg::PAR_W-1:0]  slope_reg;
    logic signed [plsg_pkg::PAR_W-1:0]  offset_reg;

    // per-sample scratch
    logic [plsg_pkg::TIME_W-1:0]        t_reg;
    logic signed [plsg_pkg::VALUE_W-1:0] y_reg;
    logic [plsg_pkg::YY_W-1:0]          yy_reg;
    logic [plsg_pkg::SXX_W-1:0]         sxx_new_reg;
    logic signed [plsg_pkg::SXY_W-1:0]  sxy_new_reg;
    logic [plsg_pkg::DX_W-1:0]          dx_reg;
    logic [plsg_pkg::DY_W-1:0]          dy_reg;
    logic [plsg_pkg::NXY_W-1:0]         nxy_mag_reg;
    logic                               nxy_neg_reg;
    logic [plsg_pkg::LHS_W-1:0]         lhs_reg;
    logic [plsg_pkg::TT_W-1:0]          tt_reg;
    logic [plsg_pkg::NCM_W-1:0]         ncm_mag_reg;
    logic                               ncm_neg_reg;
    logic signed [plsg_pkg::FIT_W-1:0]  end_val_reg;

    // output word
    logic [plsg_pkg::TIME_W-1:0]        point_time_reg;
    logic signed [plsg_pkg::FIT_W-1:0]  fit_value_reg;
    logic                               last_reg;

    // shared units
    logic                               mac_start;
    plsg_pkg::mac_cmd_t                 mac_cmd;
    plsg_pkg::unit_sts_t                mac_sts;
    logic signed [plsg_pkg::ACC_W-1:0]  mac_acc;
    logic                               div_start;
    logic [plsg_pkg::NUM_W-1:0]         div_num;
    plsg_pkg::unit_sts_t                div_sts;
    logic [plsg_pkg::QUOT_W-2:0]        div_quot;

    // derived values
    logic                               in_accept;
    logic                               out_accept;
    logic                               cfg_write;
    logic [plsg_pkg::TIME_W-1:0]        x_full;
    logic [plsg_pkg::TIME_W-1:0]        xe_full;
    logic [plsg_pkg::X_BITS-1:0]        x;
    logic [plsg_pkg::X_BITS-1:0]        xe;
    logic                               overlong;
    logic [plsg_pkg::COUNT_W-1:0]       n_new;
    logic [plsg_pkg::SX_W-1:0]          sx_new;
    logic signed [plsg_pkg::SY_W-1:0]   sy_new;
    logic [plsg_pkg::SYY_W-1:0]         syy_new;
    logic                               y_neg;
    logic [plsg_pkg::VALUE_W-1:0]       y_mag;
    logic                               sy_neg;
    logic [plsg_pkg::SY_W-1:0]          sy_mag;
    logic                               sxy_neg;
    logic [plsg_pkg::SXY_W-1:0]         sxy_mag;
    logic [plsg_pkg::PAR_W-1:0]         slope_mag;
    logic [plsg_pkg::ACC_W-1:0]         acc_mag;
    logic                               r2_close;
    logic [plsg_pkg::DX_W-1:0]          half_dx;
    logic [plsg_pkg::TT_W:0]            term_sum;
    logic [plsg_pkg::TERM_W-1:0]        term;
    logic signed [plsg_pkg::SUM_W-1:0]  off_scaled;
    logic signed [plsg_pkg::SUM_W-1:0]  end_sum;
    logic signed [plsg_pkg::PAR_W-1:0]  quot_signed_s;
    logic signed [plsg_pkg::PAR_W-1:0]  quot_signed_o;
    logic                               unit_done;

    // ------------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------------
    assign in_accept  = sample_valid && !sample_stall;
    assign out_accept = point_valid && !point_stall;
    assign cfg_write  = psel && penable && pwrite && pready;

    assign sample_stall = (state_reg != plsg_pkg::ST_IDLE);
    assign point_valid  = (state_reg == plsg_pkg::ST_EMIT0)
                       || (state_reg == plsg_pkg::ST_EMIT1);
    assign point_time   = point_time_reg;
    assign fit_value    = fit_value_reg;
    assign last         = last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == plsg_pkg::REG_R2)
                  ? plsg_pkg::DATA_W'(thr_reg) : '0;

    // ------------------------------------------------------------------------
    // sample position and new sums
    // ------------------------------------------------------------------------
    assign x_full   = (t_reg - wst_reg) >> plsg_pkg::TIME_SHIFT;
    assign xe_full  = (prev_reg - wst_reg) >> plsg_pkg::TIME_SHIFT;
    assign x        = x_full[plsg_pkg::X_BITS-1:0];
    assign xe       = xe_full[plsg_pkg::X_BITS-1:0];
    // earlier sample, full window or too long a span all close the window
    assign overlong = (count_reg >= plsg_pkg::COUNT_W'(plsg_pkg::MAX_POINTS))
                   || (t_reg < wst_reg)
                   || (|x_full[plsg_pkg::TIME_W-1:plsg_pkg::X_BITS]);

    assign n_new   = count_reg + 1'b1;
    assign sx_new  = sum_x_reg + plsg_pkg::SX_W'(x);
    assign sy_new  = sum_y_reg + plsg_pkg::SY_W'(y_reg);
    assign syy_new = sum_yy_reg + plsg_pkg::SYY_W'(yy_reg);

    assign y_neg   = y_reg[plsg_pkg::VALUE_W-1];
    assign y_mag   = y_neg ? plsg_pkg::VALUE_W'(-y_reg) : plsg_pkg::VALUE_W'(y_reg);
    assign sy_neg  = sy_new[plsg_pkg::SY_W-1];
    assign sy_mag  = sy_neg ? plsg_pkg::SY_W'(-sy_new) : plsg_pkg::SY_W'(sy_new);
    assign sxy_neg = sxy_new_reg[plsg_pkg::SXY_W-1];
    assign sxy_mag = sxy_neg ? plsg_pkg::SXY_W'(-sxy_new_reg)
                             : plsg_pkg::SXY_W'(sxy_new_reg);
    assign slope_mag = slope_reg[plsg_pkg::PAR_W-1] ? plsg_pkg::PAR_W'(-slope_reg)
                                                    : plsg_pkg::PAR_W'(slope_reg);
    assign acc_mag = mac_acc[plsg_pkg::ACC_W-1] ? plsg_pkg::ACC_W'(-mac_acc)
                                                : plsg_pkg::ACC_W'(mac_acc);

    // r2 test without square root: nxy^2 * 2^16 against dx * dy * threshold
    assign r2_close = ({lhs_reg, {plsg_pkg::R2_SHIFT{1'b0}}}
                    < (plsg_pkg::LHS_W + plsg_pkg::R2_SHIFT)'(mac_acc));

    assign half_dx = dx_reg >> 1;

    // end point value: offset * 2^5 plus rounded slope * x
    assign term_sum   = (plsg_pkg::TT_W + 1)'(mac_acc[plsg_pkg::TT_W-1:0])
                      + (plsg_pkg::TT_W + 1)'(1 << (plsg_pkg::TERM_SHIFT - 1));
    assign term       = term_sum[plsg_pkg::TERM_SHIFT +: plsg_pkg::TERM_W];
    assign off_scaled = plsg_pkg::SUM_W'(offset_reg) <<< plsg_pkg::END_SCALE;
    assign end_sum    = slope_reg[plsg_pkg::PAR_W-1]
                      ? off_scaled - $signed(plsg_pkg::SUM_W'(term))
                      : off_scaled + $signed(plsg_pkg::SUM_W'(term));

    assign quot_signed_s = nxy_neg_reg ? -$signed(plsg_pkg::PAR_W'(div_quot))
                                       :  $signed(plsg_pkg::PAR_W'(div_quot));
    assign quot_signed_o = ncm_neg_reg ? -$signed(plsg_pkg::PAR_W'(div_quot))
                                       :  $signed(plsg_pkg::PAR_W'(div_quot));

    // ------------------------------------------------------------------------
    // shared units
    // ------------------------------------------------------------------------
    plsg_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .cmd   (mac_cmd),
        .sts   (mac_sts),
        .acc   (mac_acc)
    );

    plsg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dx_reg),
        .sts   (div_sts),
        .quot  (div_quot)
    );

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plsg_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = plsg_pkg::ST_MUL_YY;
                end
            end
            plsg_pkg::ST_MUL_YY:
            begin
                if (mac_sts.done)
                begin
                    priority if (count_reg == '0)
                    begin
                        state_next = plsg_pkg::ST_RESTART;
                    end
                    else if (overlong)
                    begin
                        state_next = plsg_pkg::ST_FIT_END;
                    end
                    else
                    begin
                        state_next = plsg_pkg::ST_MUL_XX;
                    end
                end
            end
            plsg_pkg::ST_MUL_XX: if (mac_sts.done) state_next = plsg_pkg::ST_MUL_XY;
            plsg_pkg::ST_MUL_XY: if (mac_sts.done) state_next = plsg_pkg::ST_DX_A;
            plsg_pkg::ST_DX_A:   if (mac_sts.done) state_next = plsg_pkg::ST_DX_B;
            plsg_pkg::ST_DX_B:
            begin
                // no time spread: keep the fit, update the sums only
                if (mac_sts.done)
                begin
                    state_next = (mac_acc == '0) ? plsg_pkg::ST_COMMIT : plsg_pkg::ST_DY_A;
                end
            end
            plsg_pkg::ST_DY_A:   if (mac_sts.done) state_next = plsg_pkg::ST_DY_B;
            plsg_pkg::ST_DY_B:   if (mac_sts.done) state_next = plsg_pkg::ST_NXY_A;
            plsg_pkg::ST_NXY_A:  if (mac_sts.done) state_next = plsg_pkg::ST_NXY_B;
            plsg_pkg::ST_NXY_B:
            begin
                // flat values never close on the r2 test
                if (mac_sts.done)
                begin
                    state_next = (dy_reg == '0) ? plsg_pkg::ST_NCM_A : plsg_pkg::ST_SQ;
                end
            end
            plsg_pkg::ST_SQ:     if (mac_sts.done) state_next = plsg_pkg::ST_DYT;
            plsg_pkg::ST_DYT:    if (mac_sts.done) state_next = plsg_pkg::ST_RHS;
            plsg_pkg::ST_RHS:
            begin
                if (mac_sts.done)
                begin
                    state_next = r2_close ? plsg_pkg::ST_FIT_END : plsg_pkg::ST_NCM_A;
                end
            end
            plsg_pkg::ST_NCM_A:  if (mac_sts.done) state_next = plsg_pkg::ST_NCM_B;
            plsg_pkg::ST_NCM_B:  if (mac_sts.done) state_next = plsg_pkg::ST_DIV_S;
            plsg_pkg::ST_DIV_S:  if (div_sts.done) state_next = plsg_pkg::ST_DIV_O;
            plsg_pkg::ST_DIV_O:  if (div_sts.done) state_next = plsg_pkg::ST_COMMIT;
            plsg_pkg::ST_COMMIT: state_next = plsg_pkg::ST_IDLE;
            plsg_pkg::ST_FIT_END: if (mac_sts.done) state_next = plsg_pkg::ST_EMIT0;
            plsg_pkg::ST_EMIT0:  if (!point_stall) state_next = plsg_pkg::ST_EMIT1;
            plsg_pkg::ST_EMIT1:  if (!point_stall) state_next = plsg_pkg::ST_RESTART;
            plsg_pkg::ST_RESTART: state_next = plsg_pkg::ST_IDLE;
            default:             state_next = plsg_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // unit commands
    // ------------------------------------------------------------------------
    always_comb
    begin
        mac_cmd   = '0;
        mac_start = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        unit_done = 1'b0;
        unique case (state_reg)
            plsg_pkg::ST_MUL_YY:
            begin
                mac_cmd.a     = plsg_pkg::MAC_A_W'(y_mag);
                mac_cmd.b     = plsg_pkg::MAC_B_W'(y_mag);
                mac_cmd.clear = 1'b1;
            end
            plsg_pkg::ST_MUL_XX:
            begin
                mac_cmd.a          = plsg_pkg::MAC_A_W'(x);
                mac_cmd.b          = plsg_pkg::MAC_B_W'(x);
                mac_cmd.last_digit = 2'd1;
                mac_cmd.clear      = 1'b1;
            end
            plsg_pkg::ST_MUL_XY:
            begin
                mac_cmd.a     = plsg_pkg::MAC_A_W'(x);
                mac_cmd.a_neg = y_neg;
                mac_cmd.b     = plsg_pkg::MAC_B_W'(y_mag);
                mac_cmd.clear = 1'b1;
            end
            plsg_pkg::ST_DX_A:
            begin
                mac_cmd.a     = plsg_pkg::MAC_A_W'(sxx_new_reg);
                mac_cmd.b     = plsg_pkg::MAC_B_W'(n_new);
                mac_cmd.clear = 1'b1;
            end
            plsg_pkg::ST_DX_B:
            begin
                mac_cmd.a          = plsg_pkg::MAC_A_W'(sx_new);
                mac_cmd.a_neg      = 1'b1;
                mac_cmd.b          = plsg_pkg::MAC_B_W'(sx_new);
                mac_cmd.last_digit = 2'd1;
            end
            plsg_pkg::ST_DY_A:
            begin
                mac_cmd.a     = plsg_pkg::MAC_A_W'(syy_new);
                mac_cmd.b     = plsg_pkg::MAC_B_W'(n_new);
                mac_cmd.clear = 1'b1;
            end
            plsg_pkg::ST_DY_B:
            begin
                mac_cmd.a          = plsg_pkg::MAC_A_W'(sy_mag);
                mac_cmd.a_neg      = 1'b1;
                mac_cmd.b          = plsg_pkg::MAC_B_W'(sy_mag);
                mac_cmd.last_digit = 2'd1;
            end
            plsg_pkg::ST_NXY_A:
            begin
                mac_cmd.a     = plsg_pkg::MAC_A_W'(sxy_mag);
                mac_cmd.a_neg = sxy_neg;
                mac_cmd.b     = plsg_pkg::MAC_B_W'(n_new);
                mac_cmd.clear = 1'b1;
            end
            plsg_pkg::ST_NXY_B:
            begin
                mac_cmd.a          = plsg_pkg::MAC_A_W'(sx_new);
                mac_cmd.a_neg      = !sy_neg;
                mac_cmd.b          = plsg_pkg::MAC_B_W'(sy_mag);
                mac_cmd.last_digit = 2'd1;
            end
            plsg_pkg::ST_SQ:
            begin
                mac_cmd.a          = plsg_pkg::MAC_A_W'(nxy_mag_reg);
                mac_cmd.b          = plsg_pkg::MAC_B_W'(nxy_mag_reg);
                mac_cmd.last_digit = 2'd3;
                mac_cmd.clear      = 1'b1;
            end
            plsg_pkg::ST_DYT:
            begin
                mac_cmd.a     = plsg_pkg::MAC_A_W'(dy_reg);
                mac_cmd.b     = plsg_pkg::MAC_B_W'(thr_reg);
                mac_cmd.clear = 1'b1;
            end
            plsg_pkg::ST_RHS:
            begin
                mac_cmd.a          = plsg_pkg::MAC_A_W'(tt_reg);
                mac_cmd.b          = plsg_pkg::MAC_B_W'(dx_reg);
                mac_cmd.last_digit = 2'd3;
                mac_cmd.clear      = 1'b1;
            end
            plsg_pkg::ST_NCM_A:
            begin
                mac_cmd.a          = plsg_pkg::MAC_A_W'(sxx_new_reg);
                mac_cmd.a_neg      = sy_neg;
                mac_cmd.b          = plsg_pkg::MAC_B_W'(sy_mag);
                mac_cmd.last_digit = 2'd1;
                mac_cmd.clear      = 1'b1;
            end
            plsg_pkg::ST_NCM_B:
            begin
                mac_cmd.a          = plsg_pkg::MAC_A_W'(sxy_mag);
                mac_cmd.a_neg      = !sxy_neg;
                mac_cmd.b          = plsg_pkg::MAC_B_W'(sx_new);
                mac_cmd.last_digit = 2'd1;
            end
            plsg_pkg::ST_FIT_END:
            begin
                mac_cmd.a          = plsg_pkg::MAC_A_W'(slope_mag);
                mac_cmd.b          = plsg_pkg::MAC_B_W'(xe);
                mac_cmd.last_digit = 2'd1;
                mac_cmd.clear      = 1'b1;
            end
            plsg_pkg::ST_DIV_S:
            begin
                div_num = (plsg_pkg::NUM_W'(nxy_mag_reg) << plsg_pkg::SLOPE_FRAC)
                        + plsg_pkg::NUM_W'(half_dx);
            end
            plsg_pkg::ST_DIV_O:
            begin
                div_num = (plsg_pkg::NUM_W'(ncm_mag_reg) << plsg_pkg::OFFSET_FRAC)
                        + plsg_pkg::NUM_W'(half_dx);
            end
            default:
            begin
                mac_cmd = '0;
            end
        endcase

        unique case (state_reg)
            plsg_pkg::ST_MUL_YY, plsg_pkg::ST_MUL_XX, plsg_pkg::ST_MUL_XY,
            plsg_pkg::ST_DX_A, plsg_pkg::ST_DX_B, plsg_pkg::ST_DY_A, plsg_pkg::ST_DY_B,
            plsg_pkg::ST_NXY_A, plsg_pkg::ST_NXY_B, plsg_pkg::ST_SQ, plsg_pkg::ST_DYT,
            plsg_pkg::ST_RHS, plsg_pkg::ST_NCM_A, plsg_pkg::ST_NCM_B, plsg_pkg::ST_FIT_END:
            begin
                mac_start = !launched_reg;
                unit_done = mac_sts.done;
            end
            plsg_pkg::ST_DIV_S, plsg_pkg::ST_DIV_O:
            begin
                div_start = !launched_reg;
                unit_done = div_sts.done;
            end
            default:
            begin
                unit_done = 1'b0;
            end
        endcase

        launched_next = (mac_start || div_start || launched_reg) && !unit_done;
    end

    // ------------------------------------------------------------------------
    // control and window state
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= plsg_pkg::ST_IDLE;
            launched_reg <= 1'b0;
            thr_reg      <= plsg_pkg::R2_RESET;
            count_reg    <= '0;
            wst_reg      <= '0;
            prev_reg     <= '0;
            sum_x_reg    <= '0;
            sum_xx_reg   <= '0;
            sum_xy_reg   <= '0;
            sum_y_reg    <= '0;
            sum_yy_reg   <= '0;
            slope_reg    <= '0;
            offset_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;

            if (cfg_write && (paddr[2] == plsg_pkg::REG_R2))
            begin
                thr_reg <= pwdata[plsg_pkg::THR_W-1:0];
            end

            if ((state_reg == plsg_pkg::ST_DIV_S) && div_sts.done)
            begin
                slope_reg <= quot_signed_s;
            end
            if ((state_reg == plsg_pkg::ST_DIV_O) && div_sts.done)
            begin
                offset_reg <= quot_signed_o;
            end

            if (state_reg == plsg_pkg::ST_COMMIT)
            begin
                count_reg  <= n_new;
                prev_reg   <= t_reg;
                sum_x_reg  <= sx_new;
                sum_xx_reg <= sxx_new_reg;
                sum_xy_reg <= sxy_new_reg;
                sum_y_reg  <= sy_new;
                sum_yy_reg <= syy_new;
            end

            // new window holds the current sample alone
            if (state_reg == plsg_pkg::ST_RESTART)
            begin
                count_reg  <= plsg_pkg::COUNT_W'(1);
                wst_reg    <= t_reg;
                prev_reg   <= t_reg;
                sum_x_reg  <= '0;
                sum_xx_reg <= '0;
                sum_xy_reg <= '0;
                sum_y_reg  <= plsg_pkg::SY_W'(y_reg);
                sum_yy_reg <= plsg_pkg::SYY_W'(yy_reg);
            end
        end
    end

    // ------------------------------------------------------------------------
    // scratch and output word
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            t_reg <= sample_time;
            y_reg <= sample_value;
        end

        if (mac_sts.done)
        begin
            unique case (state_reg)
                plsg_pkg::ST_MUL_YY: yy_reg <= mac_acc[plsg_pkg::YY_W-1:0];
                plsg_pkg::ST_MUL_XX:
                begin
                    sxx_new_reg <= sum_xx_reg + mac_acc[plsg_pkg::SXX_W-1:0];
                end
                plsg_pkg::ST_MUL_XY:
                begin
                    sxy_new_reg <= sum_xy_reg + $signed(mac_acc[plsg_pkg::SXY_W-1:0]);
                end
                plsg_pkg::ST_DX_B: dx_reg <= mac_acc[plsg_pkg::DX_W-1:0];
                plsg_pkg::ST_DY_B: dy_reg <= mac_acc[plsg_pkg::DY_W-1:0];
                plsg_pkg::ST_NXY_B:
                begin
                    nxy_neg_reg <= mac_acc[plsg_pkg::ACC_W-1];
                    nxy_mag_reg <= acc_mag[plsg_pkg::NXY_W-1:0];
                end
                plsg_pkg::ST_SQ:  lhs_reg <= mac_acc[plsg_pkg::LHS_W-1:0];
                plsg_pkg::ST_DYT: tt_reg  <= mac_acc[plsg_pkg::TT_W-1:0];
                plsg_pkg::ST_NCM_B:
                begin
                    ncm_neg_reg <= mac_acc[plsg_pkg::ACC_W-1];
                    ncm_mag_reg <= acc_mag[plsg_pkg::NCM_W-1:0];
                end
                plsg_pkg::ST_FIT_END:
                begin
                    // start point first, end value kept for the second word
                    end_val_reg    <= plsg_pkg::sat_fit(end_sum);
                    point_time_reg <= wst_reg;
                    fit_value_reg  <= plsg_pkg::sat_fit(off_scaled);
                    last_reg       <= 1'b0;
                end
                default:
                begin
                    end_val_reg <= end_val_reg;
                end
            endcase
        end

        if ((state_reg == plsg_pkg::ST_EMIT0) && out_accept)
        begin
            point_time_reg <= prev_reg;
            fit_value_reg  <= end_val_reg;
            last_reg       <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> sample_stall)
        else $error("output word pending while a sample can be taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        mac_start |-> !mac_sts.busy)
        else $error("multiplier started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_sts.busy)
        else $error("divider started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= plsg_pkg::COUNT_W'(plsg_pkg::MAX_POINTS))
        else $error("window count beyond the window size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && last) |=> (state_reg == plsg_pkg::ST_RESTART))
        else $error("window not restarted after the end point");

endmodule

/* tb/piecewise_linear_segmenter_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_linear_segmenter_core_test
// Drives timestamped samples into the segmenter, predicts every emitted
// segment point from its own least-squares model and checks each point word.
// ----------------------------------------------------------------------------
module piecewise_linear_segmenter_core_test;
    import plsg_pkg::*;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  SETTLE      = 300;
    localparam longint FIT_MAX  = 64'h7FFF_FFFF_FFFF;
    localparam logic [62:0] TIME_TOP = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ADDR_W-1:0] R2_ADDR = ADDR_W'(4 * REG_R2);

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic [TIME_W-1:0]          sample_time = '0;
    logic signed [VALUE_W-1:0]  sample_value = '0;
    logic                       point_valid;
    logic                       point_stall = 1'b0;
    logic [TIME_W-1:0]          point_time;
    logic signed [FIT_W-1:0]    fit_value;
    logic                       last;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_W-1:0]          paddr = '0;
    logic [DATA_W-1:0]          pwdata = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    piecewise_linear_segmenter_core DUT (.*);

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // segment model state
    // ------------------------------------------------------------------
    typedef struct {
        logic [62:0] ptime;
        logic [31:0] fval;
        logic        is_end;
    } point_t;

    point_t      pending_points[$];
    logic [15:0] r2_limit;
    logic [63:0] win_count, win_start, win_prev, acc_x, acc_xx, acc_yy;
    longint      acc_xy, acc_y, line_slope, line_offset;

    int errors = 0;
    int samples_sent = 0;
    int points_seen = 0;
    int closes_made = 0;
    int cycles = 0;
    bit long_hold = 1'b0;
    bit quiet = 1'b0;

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // signed-magnitude (+-a) - (+-b)
    function automatic logic [127:0] signed_diff(input bit na, input logic [127:0] a,
                                                 input bit nb, input logic [127:0] b,
                                                 output bit nr);
        nb = !nb;
        if (na == nb) begin
            nr = na;
            return a + b;
        end
        if (a < b) begin
            nr = nb;
            return b - a;
        end
        nr = na;
        return a - b;
    endfunction

    // rounded, saturated (m * 2^fb) / d
    function automatic longint fit_divide(input bit neg, input logic [127:0] m,
                                          input int fb, input logic [63:0] d);
        logic [127:0] q;
        logic [63:0]  qs;
        q  = ((m << fb) + 128'(d >> 1)) / 128'(d);
        qs = (q > 128'(FIT_MAX)) ? 64'(FIT_MAX) : q[63:0];
        return neg ? -longint'(qs) : longint'(qs);
    endfunction

    // fitted Q16.16 value at x
    function automatic logic [31:0] line_value(input logic [63:0] x);
        logic [127:0] term;
        logic [63:0]  tm;
        longint       v;
        term = (128'(magnitude(line_slope)) * 128'(x) + 128'd128) >> 8;
        tm   = (term > 128'(64'h1000_0000_0000_0000)) ? 64'h1000_0000_0000_0000 : term[63:0];
        v    = line_offset * 32;
        v    = line_slope < 0 ? v - longint'(tm) : v + longint'(tm);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic close_window();
        point_t p;
        p.ptime  = win_start[62:0];
        p.fval   = line_value(64'd0);
        p.is_end = 1'b0;
        pending_points.push_back(p);
        p.ptime  = win_prev[62:0];
        p.fval   = line_value((win_prev - win_start) >> TIME_SHIFT);
        p.is_end = 1'b1;
        pending_points.push_back(p);
        closes_made++;
    endtask

    task automatic open_window(input logic [63:0] t, input longint y);
        win_count = 1;
        win_start = t;
        win_prev  = t;
        acc_x     = 0;
        acc_xx    = 0;
        acc_xy    = 0;
        acc_y     = y;
        acc_yy    = 64'(y * y);
    endtask

    // advance the window by one accepted sample word
    task automatic model_sample(input logic [62:0] ts, input logic signed [15:0] vs);
        logic [63:0]  t, x, n, sx, sxx, syy, dx, dy;
        longint       y, sxy, sy;
        logic [127:0] nxy, ncm, lhs, rhs;
        bit           nxy_neg, ncm_neg;
        t = {1'b0, ts};
        y = longint'(vs);
        if (win_count == 0) begin
            open_window(t, y);
            return;
        end
        x = (t - win_start) >> TIME_SHIFT;
        if (win_count >= MAX_POINTS || t < win_start || (x >> X_BITS) != 0) begin
            close_window();
            open_window(t, y);
            return;
        end
        n   = win_count + 1;
        sx  = acc_x + x;
        sxx = acc_xx + x * x;
        sxy = acc_xy + longint'(x) * y;
        sy  = acc_y + y;
        syy = acc_yy + 64'(y * y);
        dx  = n * sxx - sx * sx;
        if (dx != 0) begin
            dy  = n * syy - magnitude(sy) * magnitude(sy);
            nxy = signed_diff(sxy < 0, 128'(n) * 128'(magnitude(sxy)),
                              sy < 0, 128'(sx) * 128'(magnitude(sy)), nxy_neg);
            if (dy != 0) begin
                lhs = (128'(nxy[63:0]) * 128'(nxy[63:0])) << R2_SHIFT;
                rhs = (128'(dx) * 128'(dy)) * 128'(r2_limit);
                // correlation dropped below the threshold
                if (nxy[127:64] == 0 && lhs < rhs) begin
                    close_window();
                    open_window(t, y);
                    return;
                end
            end
            ncm = signed_diff(sy < 0, 128'(magnitude(sy)) * 128'(sxx),
                              sxy < 0, 128'(sx) * 128'(magnitude(sxy)), ncm_neg);
            line_slope  = fit_divide(nxy_neg, nxy, SLOPE_FRAC, dx);
            line_offset = fit_divide(ncm_neg, ncm, OFFSET_FRAC, dx);
        end
        win_count = n;
        win_prev  = t;
        acc_x     = sx;
        acc_xx    = sxx;
        acc_xy    = sxy;
        acc_y     = sy;
        acc_yy    = syy;
    endtask

    // ------------------------------------------------------------------
    // timeout
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout at %0t with %0d points pending", $time, pending_points.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // point checker: every taken word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        point_t p;
        if (rst_n && point_valid && !point_stall)
        begin
            points_seen++;
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected point word time=%0d fit=%0d last=%0b",
                         $time, point_time, fit_value, last);
                errors++;
            end
            else
            begin
                p = pending_points.pop_front();
                if (point_time !== p.ptime)
                begin
                    $display("%0t: point_time expected %0d actual %0d", $time, p.ptime, point_time);
                    errors++;
                end
                if (fit_value !== p.fval)
                begin
                    $display("%0t: fit_value expected %0d actual %0d",
                             $time, $signed(p.fval), fit_value);
                    errors++;
                end
                if (last !== p.is_end)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, p.is_end, last);
                    errors++;
                end
            end
        end
    end

    // receiver stall: random, a long hold on request, none in quiet stretches
    always @(negedge clk)
    begin
        if (long_hold)
            point_stall <= 1'b1;
        else if (quiet)
            point_stall <= 1'b0;
        else
            point_stall <= ($urandom_range(99) < 30);
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(120, 20);
    endfunction

    // offer one sample word until it is taken
    task automatic send_sample(input logic [62:0] t, input logic signed [15:0] v);
        int gap;
        @(negedge clk);
        sample_valid = 1'b1;
        sample_time  = t;
        sample_value = v;
        do
            @(posedge clk);
        while (sample_stall);
        model_sample(t, v);
        samples_sent++;
        gap = gap_length();
        if (gap > 0)
        begin
            @(negedge clk);
            sample_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        sample_valid = 1'b0;
        wait (pending_points.size() == 0);
        // a sample that closes nothing may still be in the fit
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        @(negedge clk);
        psel   = 1'b1;
        pwrite = 1'b1;
        paddr  = R2_ADDR;
        pwdata = 32'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        r2_limit = value;
        // read it back
        psel = 1'b1;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[15:0] !== value)
        begin
            $display("%0t: r2_threshold readback expected %0d actual %0d", $time, value, prdata);
            errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic logic [62:0] random_time();
        return {$urandom(), $urandom()} & 63'h3FFF_FFFF_FFFF_FFFF;
    endfunction

    // one line with random slope and noise, sampled at random spacing
    task automatic send_line(input int count, inout logic [62:0] t);
        longint base, slope, noise;
        base  = longint'($urandom_range(65535)) - 32768;
        slope = longint'($urandom_range(8000)) - 4000;
        noise = $urandom_range(3) == 0 ? 0 : $urandom_range(400);
        for (int i = 0; i < count; i++)
        begin
            t = t + 63'($urandom_range(60000, 1024));
            send_sample(t, clip16(base + slope * i / 4 +
                                  longint'($urandom_range(2 * noise)) - noise));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_special_cases();
        logic [62:0] t;
        // window open at time zero, then zero value spread
        send_sample(63'd0, 16'sd0);
        send_sample(63'd2048, 16'sd0);
        send_sample(63'd4096, 16'sd0);
        // zero time spread
        send_sample(63'd4096, -16'sd32768);
        send_sample(63'd4096, 16'sd32767);
        // a sharp turn against the extremes
        send_sample(63'd8192, 16'sd32767);
        send_sample(63'd9216, -16'sd32768);
        send_sample(63'd10240, 16'sd32767);
        // earlier sample than the one before it
        t = 63'd1000000;
        send_sample(t, 16'sd100);
        send_sample(t - 63'd5000, 16'sd200);
        // span past the limit, then a sample earlier than the new window start
        send_sample(t + 63'((64'd1 << (X_BITS + TIME_SHIFT)) - 1), 16'sd300);
        send_sample(t - 63'd5000 + 63'(64'd1 << (X_BITS + TIME_SHIFT)), 16'sd400);
        // highest timestamps
        send_sample(TIME_TOP - 63'd3000, -16'sd5);
        send_sample(TIME_TOP - 63'd2000, 16'sd5);
        send_sample(TIME_TOP, -16'sd32768);
        // far back in time closes again
        send_sample(63'd1, 16'sd1);
        send_sample(63'h2AAA_AAAA_AAAA_AAAA, -16'sd21846);
        send_sample(63'h5555_5555_5555_5555, 16'sd21845);
        drain();
    endtask

    task automatic test_full_window();
        logic [62:0] t;
        t = random_time();
        quiet = 1'b1;
        for (int i = 0; i <= MAX_POINTS; i++)
            send_sample(t, 16'($urandom()));
        quiet = 1'b0;
        drain();
    endtask

    task automatic test_lines(input int words);
        logic [62:0] t;
        int goal;
        t = random_time();
        goal = samples_sent + words;
        while (samples_sent < goal)
        begin
            case ($urandom_range(9))
                0: send_sample(random_time(), 16'($urandom()));
                1: t = t + 63'(64'd1 << (X_BITS + TIME_SHIFT));
                2: t = random_time();
                3: quiet = !quiet;
                default: send_line($urandom_range(24, 3), t);
            endcase
        end
        quiet = 1'b0;
        drain();
    endtask

    // output held off for long while samples keep coming, then a pause
    task automatic test_back_pressure();
        logic [62:0] t;
        t = random_time();
        fork
            begin
                long_hold = 1'b1;
                repeat (1500) @(negedge clk);
                long_hold = 1'b0;
            end
            for (int i = 0; i < 4; i++)
                send_line(6, t);
        join
        wait (pending_points.size() == 0);
        send_line(8, t);
        drain();
    endtask

    initial
    begin
        r2_limit    = R2_RESET;
        win_count   = 0;
        win_start   = 0;
        win_prev    = 0;
        acc_x       = 0;
        acc_xx      = 0;
        acc_xy      = 0;
        acc_y       = 0;
        acc_yy      = 0;
        line_slope  = 0;
        line_offset = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_special_cases();
        test_lines(300);
        test_back_pressure();
        write_threshold(16'd0);
        test_lines(150);
        write_threshold(16'hFFFF);
        test_lines(150);
        write_threshold(16'($urandom()));
        test_full_window();
        test_lines(150);
        write_threshold(R2_RESET);
        test_lines(100);

        $display("%0d samples sent, %0d point words checked, %0d segments closed",
                 samples_sent, points_seen, closes_made);
        $display("covered r2 limits 0, 0.95, 1.0 and random, full window, span and order closes");
        if (errors == 0 && pending_points.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/plsg_pkg.sv
rtl/core/plsg_mac.sv
rtl/core/plsg_div.sv
rtl/core/piecewise_linear_segmenter_core.sv
tb/piecewise_linear_segmenter_core_test.sv
